@@ rtl/plane_nearest_match_assert.svh @@
// Assertion macros for the plane_nearest_match block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef PLANE_NEAREST_MATCH_ASSERT_SVH
`define PLANE_NEAREST_MATCH_ASSERT_SVH
`ifndef SYNTH
// Check a property on a named clock with a named active-low reset.
`define PNM_ASSERT_CLK(lbl, ck, rstn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);
// Check a property on the block clock clk with reset rst_n.
`define PNM_ASSERT(lbl, prop, msg) \
  `PNM_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`else
`define PNM_ASSERT_CLK(lbl, ck, rstn, prop, msg)
`define PNM_ASSERT(lbl, prop, msg)
`endif
`endif

@@ rtl/pnm_pkg.sv @@
// Shared types and constants for the plane_nearest_match block.
// No dependencies; imported by every module of the block.
`default_nettype none
package pnm_pkg;

  // Field widths
  localparam int FIELD_W   = 16;
  localparam int TAG_W     = 8;
  localparam int SLOT_W    = 4;
  localparam int CNT_W     = 5;
  localparam int PLANE_W   = 64;
  localparam int ERR_W     = 63;

  // Table depth default
  localparam int DEFAULT_TABLE_DEPTH = 16;

  // Item modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Saturation limit of the error
  localparam logic [ERR_W-1:0] ERR_LIM = '1;

  // Tag that travels with each table entry through the error pipeline
  typedef struct packed {
    logic             vld;
    logic [CNT_W-1:0] idx;
  } pnm_ctl_t;

  // Address width for a memory of the given depth
  function automatic int addr_w(int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage
`default_nettype wire

@@ rtl/pnm_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
// Uses pnm_pkg for the address width helper.
`default_nettype none
module pnm_ram #(
  parameter int WIDTH = pnm_pkg::PLANE_W,
  parameter int DEPTH = pnm_pkg::DEFAULT_TABLE_DEPTH,
  localparam int AW   = pnm_pkg::addr_w(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic             re,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);
  import pnm_pkg::*;

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[addr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/pnm_err.sv @@
// Four-stage error pipeline: one table entry in, one error out per cycle.
// Uses pnm_pkg for widths and the entry control struct.
`default_nettype none
module pnm_err (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic signed [pnm_pkg::FIELD_W-1:0]  q_nx,
  input  wire logic signed [pnm_pkg::FIELD_W-1:0]  q_ny,
  input  wire logic signed [pnm_pkg::FIELD_W-1:0]  q_nz,
  input  wire logic signed [pnm_pkg::FIELD_W-1:0]  q_off,
  input  wire logic        [pnm_pkg::PLANE_W-1:0]  rd_data,
  input  wire pnm_pkg::pnm_ctl_t                   in_ctl,
  output logic             [pnm_pkg::ERR_W-1:0]    err,
  output pnm_pkg::pnm_ctl_t                        out_ctl
);
  import pnm_pkg::*;

  // Table entry fields
  logic signed [FIELD_W-1:0] t_nx, t_ny, t_nz, t_off;
  // Stage 1: normal difference sum and table offset square
  logic signed [18:0] s_c;
  logic signed [31:0] dt2_c;
  logic signed [18:0] s1_s_r;
  logic signed [31:0] s1_dt2_r;
  logic signed [31:0] dq2_r;
  // Stage 2: normal term square and offset-square difference
  logic signed [37:0] nsq_c;
  logic        [35:0] s2_nsq_r;
  logic signed [31:0] s2_w_r;
  // Stage 3: offset term square
  logic signed [63:0] osq_c;
  logic        [60:0] s3_osq_r;
  logic        [35:0] s3_nsq_r;
  // Stage 4: saturating sum
  logic        [64:0] sum_c;
  logic        [ERR_W-1:0] s4_err_r;
  pnm_ctl_t ctl1_r, ctl2_r, ctl3_r, ctl4_r;

  assign t_nx  = $signed(rd_data[15:0]);
  assign t_ny  = $signed(rd_data[31:16]);
  assign t_nz  = $signed(rd_data[47:32]);
  assign t_off = $signed(rd_data[63:48]);

  assign s_c   = (19'(q_nx) - 19'(t_nx)) + (19'(q_ny) - 19'(t_ny)) + (19'(q_nz) - 19'(t_nz));
  assign dt2_c = t_off * t_off;
  assign nsq_c = s1_s_r * s1_s_r;
  assign osq_c = s2_w_r * s2_w_r;
  assign sum_c = 65'({s3_nsq_r, 18'd0}) + 65'(s3_osq_r);

  // Advance entry tags; clear on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
    end else begin
      ctl1_r <= in_ctl;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    dq2_r    <= q_off * q_off;
    s1_s_r   <= s_c;
    s1_dt2_r <= dt2_c;
    s2_nsq_r <= nsq_c[35:0];
    s2_w_r   <= dq2_r - s1_dt2_r;
    s3_osq_r <= osq_c[60:0];
    s3_nsq_r <= s2_nsq_r;
    if (sum_c > 65'(ERR_LIM)) begin
      s4_err_r <= ERR_LIM;
    end else begin
      s4_err_r <= sum_c[ERR_W-1:0];
    end
  end

  assign err     = s4_err_r;
  assign out_ctl = ctl4_r;

endmodule
`default_nettype wire

@@ rtl/plane_nearest_match.sv @@
// Top level of the nearest reference plane search.
// Depends on pnm_pkg, pnm_ram, pnm_err and plane_nearest_match_assert.svh.
//
// Usage:
//   An item is taken when start is high and busy is low. in_mode selects a
//   load (write in_entry_index with the plane) or a query (compare the plane
//   against slots 0 .. table_count-1). A load gives no result; a load into a
//   slot at or above TABLE_DEPTH is dropped. A query with n =
//   min(table_count, TABLE_DEPTH) slots holds busy while one table read per
//   cycle from the plane memory goes through the four error stages to the
//   result register. A query with n = 0 returns found = 0 in the cycle after
//   it is taken, without raising busy. The result is shown for exactly one
//   cycle with out_valid high; the receiver cannot stall it, and the next
//   item may be taken in that cycle. table_count is written on the cfg
//   channel (cfg_ready is always high) by the user only while the block is
//   idle; the block does not enforce it. Reset clears table_count and all
//   control state; plane memory contents stay undefined until loaded.
`default_nettype none
module plane_nearest_match #(
  parameter int TABLE_DEPTH = pnm_pkg::DEFAULT_TABLE_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input item channel
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                in_mode,
  input  wire logic        [pnm_pkg::SLOT_W-1:0]   in_entry_index,
  input  wire logic        [pnm_pkg::TAG_W-1:0]    in_query_tag,
  input  wire logic signed [pnm_pkg::FIELD_W-1:0]  in_normal_x,
  input  wire logic signed [pnm_pkg::FIELD_W-1:0]  in_normal_y,
  input  wire logic signed [pnm_pkg::FIELD_W-1:0]  in_normal_z,
  input  wire logic signed [pnm_pkg::FIELD_W-1:0]  in_plane_offset,
  // Result channel
  output logic                                     out_valid,
  output logic             [pnm_pkg::TAG_W-1:0]    out_result_tag,
  output logic             [pnm_pkg::SLOT_W-1:0]   out_best_index,
  output logic                                     out_found,
  output logic             [pnm_pkg::ERR_W-1:0]    out_best_error,
  // Configuration channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic        [pnm_pkg::CNT_W-1:0]    cfg_data
);
  import pnm_pkg::*;

  `include "plane_nearest_match_assert.svh"

  localparam int AW = addr_w(TABLE_DEPTH);

  // Sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    table_count_r;
  logic [CNT_W-1:0]    n_c, n_r;
  logic [CNT_W-1:0]    k_r, k_nxt;
  logic                accept;
  logic                last_c;
  logic [TAG_W-1:0]    tag_r;
  logic signed [FIELD_W-1:0] q_nx_r, q_ny_r, q_nz_r, q_off_r;

  // Memory port
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_addr;
  logic [PLANE_W-1:0]  ram_wdata, ram_rdata;
  pnm_ctl_t            rd_ctl_r;

  // Error pipeline output
  logic [ERR_W-1:0]    e_err;
  pnm_ctl_t            e_ctl;

  // Running minimum
  logic                best_found_r, best_found_nxt;
  logic [ERR_W-1:0]    best_err_r, best_err_nxt;
  logic [CNT_W-1:0]    best_idx_r, best_idx_nxt;

  // Result register
  logic                out_valid_r;
  logic [TAG_W-1:0]    out_tag_r;
  logic [CNT_W-1:0]    out_idx_r;
  logic                out_found_r;
  logic [ERR_W-1:0]    out_err_r;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Clamp the slot count to the table depth
  always_comb begin
    if (32'(table_count_r) > TABLE_DEPTH) begin
      n_c = CNT_W'(TABLE_DEPTH);
    end else begin
      n_c = table_count_r;
    end
  end

  // Memory access: loads write while idle, queries read while scanning
  assign ram_we    = accept && (in_mode == MODE_LOAD) && (32'(in_entry_index) < TABLE_DEPTH);
  assign ram_re    = (state_r == ST_SCAN);
  assign ram_addr  = ram_re ? AW'(k_r) : AW'(in_entry_index);
  assign ram_wdata = {in_plane_offset, in_normal_z, in_normal_y, in_normal_x};

  pnm_ram #(
    .WIDTH (PLANE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  pnm_err u_err (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_nx    (q_nx_r),
    .q_ny    (q_ny_r),
    .q_nz    (q_nz_r),
    .q_off   (q_off_r),
    .rd_data (ram_rdata),
    .in_ctl  (rd_ctl_r),
    .err     (e_err),
    .out_ctl (e_ctl)
  );

  // Last error of the query leaves the pipeline
  assign last_c = (state_r == ST_DRAIN) && e_ctl.vld && (e_ctl.idx == n_r - CNT_W'(1));

  // Sequencer: walk the table, then wait for the pipeline to drain
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    unique case (state_r)
      ST_IDLE: begin
        k_nxt = '0;
        if (accept && (in_mode == MODE_QUERY) && (n_c != '0)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (k_r == n_r - CNT_W'(1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + CNT_W'(1);
        end
      end
      ST_DRAIN: begin
        if (last_c) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Keep the first smallest error
  always_comb begin
    best_found_nxt = best_found_r;
    best_err_nxt   = best_err_r;
    best_idx_nxt   = best_idx_r;
    if (e_ctl.vld && (!best_found_r || (e_err < best_err_r))) begin
      best_found_nxt = 1'b1;
      best_err_nxt   = e_err;
      best_idx_nxt   = e_ctl.idx;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      table_count_r <= '0;
      rd_ctl_r      <= '0;
      out_valid_r   <= 1'b0;
      best_found_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_ctl_r     <= '{vld: ram_re, idx: k_r};
      out_valid_r  <= (accept && (in_mode == MODE_QUERY) && (n_c == '0)) || last_c;
      if (cfg_valid && cfg_ready) begin
        table_count_r <= cfg_data;
      end
      if (accept) begin
        best_found_r <= 1'b0;
      end else begin
        best_found_r <= best_found_nxt;
      end
    end
  end

  // Query and datapath registers
  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    best_err_r   <= best_err_nxt;
    best_idx_r   <= best_idx_nxt;
    if (accept) begin
      n_r     <= n_c;
      tag_r   <= in_query_tag;
      q_nx_r  <= in_normal_x;
      q_ny_r  <= in_normal_y;
      q_nz_r  <= in_normal_z;
      q_off_r <= in_plane_offset;
    end
    // Load the result: empty table or final minimum
    if (accept && (in_mode == MODE_QUERY) && (n_c == '0)) begin
      out_tag_r   <= in_query_tag;
      out_idx_r   <= '0;
      out_found_r <= 1'b0;
      out_err_r   <= '0;
    end else if (last_c) begin
      out_tag_r   <= tag_r;
      out_idx_r   <= best_idx_nxt;
      out_found_r <= best_found_nxt;
      out_err_r   <= best_err_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_result_tag = out_tag_r;
  assign out_best_index = out_idx_r[SLOT_W-1:0];
  assign out_found      = out_found_r;
  assign out_best_error = out_err_r;

  // Checks
  `PNM_ASSERT(a_idle_pipe_empty, (state_r == ST_IDLE) |-> (!rd_ctl_r.vld && !e_ctl.vld), "pipeline busy while idle")
  `PNM_ASSERT(a_scan_in_range, (state_r == ST_SCAN) |-> (k_r < n_r), "scan index beyond slot count")
  `PNM_ASSERT(a_no_rw_clash, ram_we |-> !ram_re, "memory read and write in the same cycle")
  `PNM_ASSERT(a_found_in_range, (out_valid && out_found) |-> (out_idx_r < n_r), "best slot outside scanned range")
  `PNM_ASSERT(a_result_cause, out_valid |-> ($past(busy) || $past(start && in_mode == MODE_QUERY)), "result without a query")

endmodule
`default_nettype wire

@@ dv/plane_nearest_match_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for plane_nearest_match: directed table, then random load/query traffic.
// Depends on pnm_pkg and the plane_nearest_match RTL; holds its own nearest-plane predictor.
module plane_nearest_match_tb;
  import pnm_pkg::*;

  localparam int DEPTH          = DEFAULT_TABLE_DEPTH;
  localparam int RANDOM_ITEMS   = 650;
  localparam int DRAIN_CYCLES   = 30;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 30;

  typedef struct {
    logic signed [FIELD_W-1:0] nx;
    logic signed [FIELD_W-1:0] ny;
    logic signed [FIELD_W-1:0] nz;
    logic signed [FIELD_W-1:0] off;
  } plane_t;

  typedef struct {
    logic              mode;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  tag;
    plane_t            p;
  } plane_item_t;

  typedef struct {
    logic [TAG_W-1:0]  tag;
    logic [SLOT_W-1:0] idx;
    logic              found;
    logic [ERR_W-1:0]  err;
  } match_t;

  typedef struct {
    bit               is_cfg;
    logic [CNT_W-1:0] cfg_val;
    plane_item_t      item;
    bit               typed;
    match_t           exp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_mode = MODE_LOAD;
  logic [SLOT_W-1:0] in_entry_index = '0;
  logic [TAG_W-1:0] in_query_tag = '0;
  logic signed [FIELD_W-1:0] in_normal_x = '0;
  logic signed [FIELD_W-1:0] in_normal_y = '0;
  logic signed [FIELD_W-1:0] in_normal_z = '0;
  logic signed [FIELD_W-1:0] in_plane_offset = '0;
  logic out_valid;
  logic [TAG_W-1:0] out_result_tag;
  logic [SLOT_W-1:0] out_best_index;
  logic out_found;
  logic [ERR_W-1:0] out_best_error;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  // Predictor state
  plane_t           shadow_planes [DEPTH];
  logic [CNT_W-1:0] shadow_count = '0;
  match_t           expected_matches [$];
  stim_row_t        stim_rows [$];
  int               fail_count = 0;

  plane_nearest_match #(.TABLE_DEPTH(DEPTH)) u_top (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy),
    .in_mode(in_mode), .in_entry_index(in_entry_index), .in_query_tag(in_query_tag),
    .in_normal_x(in_normal_x), .in_normal_y(in_normal_y), .in_normal_z(in_normal_z),
    .in_plane_offset(in_plane_offset),
    .out_valid(out_valid), .out_result_tag(out_result_tag), .out_best_index(out_best_index),
    .out_found(out_found), .out_best_error(out_best_error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Error of one table plane against the query, 2^-48 scale, saturated
  function automatic logic [ERR_W-1:0] plane_error(plane_t q, plane_t t);
    longint s, dq, dt, w;
    bit [63:0] nterm, oterm, sum;
    s = (longint'(q.nx) - longint'(t.nx)) + (longint'(q.ny) - longint'(t.ny)) +
        (longint'(q.nz) - longint'(t.nz));
    nterm = 64'(s * s) << 18;
    dq = longint'(q.off);
    dt = longint'(t.off);
    w = dq * dq - dt * dt;
    oterm = 64'(w * w);
    sum = nterm + oterm;
    if (sum > 64'h7FFF_FFFF_FFFF_FFFF || sum < nterm) sum = 64'h7FFF_FFFF_FFFF_FFFF;
    return sum[ERR_W-1:0];
  endfunction

  // Scan the active slots and keep the first minimum
  function automatic match_t nearest_plane(plane_item_t it);
    match_t m;
    int n;
    logic [ERR_W-1:0] e;
    m = '{tag: it.tag, idx: '0, found: 1'b0, err: '0};
    n = (shadow_count > DEPTH) ? DEPTH : shadow_count;
    for (int k = 0; k < n; k++) begin
      e = plane_error(it.p, shadow_planes[k]);
      if (!m.found || e < m.err) begin
        m.err = e;
        m.idx = k[SLOT_W-1:0];
        m.found = 1'b1;
      end
    end
    return m;
  endfunction

  function automatic logic signed [FIELD_W-1:0] pick_field();
    case ($urandom_range(0, 11))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return -16'sd1;
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  task automatic add_row(bit is_cfg, logic [CNT_W-1:0] v, logic mode, int slot, int tag,
                         plane_t p, bit typed, match_t exp);
    stim_row_t r;
    r.is_cfg = is_cfg;
    r.cfg_val = v;
    r.item = '{mode: mode, slot: slot[SLOT_W-1:0], tag: tag[TAG_W-1:0], p: p};
    r.typed = typed;
    r.exp = exp;
    stim_rows.insert(stim_rows.size(), r);
  endtask

  // Drive one transaction and predict at the edge that takes it
  task automatic send_item(plane_item_t it, bit typed, match_t typed_exp);
    match_t m;
    @(negedge clk);
    start <= 1'b1;
    in_mode <= it.mode;
    in_entry_index <= it.slot;
    in_query_tag <= it.tag;
    in_normal_x <= it.p.nx;
    in_normal_y <= it.p.ny;
    in_normal_z <= it.p.nz;
    in_plane_offset <= it.p.off;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (it.mode == MODE_LOAD) shadow_planes[it.slot] = it.p;
    else begin
      m = typed ? typed_exp : nearest_plane(it);
      expected_matches.insert(expected_matches.size(), m);
    end
  endtask

  task automatic hold_off(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Drain the block, let a trailing scan finish, then write table_count
  task automatic set_table_count(logic [CNT_W-1:0] v);
    hold_off(1);
    while (expected_matches.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    shadow_count = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
    if (a !== e) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, e, a);
    end
  endtask

  // Compare each result strobe with the oldest expectation
  always @(posedge clk) begin
    match_t m;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_matches.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected result: expected none, actual tag %0h index %0h error %0h",
                   $time, out_result_tag, out_best_index, out_best_error);
      end else begin
        m = expected_matches.pop_front();
        check_field("result_tag", m.tag, out_result_tag);
        check_field("best_index", m.idx, out_best_index);
        check_field("found", m.found, out_found);
        check_field("best_error", m.err, out_best_error);
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid === 1'b1 || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    plane_t zero_p, max_p, min_p, mix_p, near_p, p;
    plane_item_t it;
    match_t none;
    int sent, burst_left, phase_len;
    logic [CNT_W-1:0] cnt;

    zero_p = '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000};
    max_p  = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
    min_p  = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
    mix_p  = '{16'sh7FFF, 16'sh8000, 16'sh1234, 16'sh0800};
    near_p = '{16'sh0001, -16'sd1, 16'sh0000, 16'sh0000};
    none   = '{tag: '0, idx: '0, found: 1'b0, err: '0};

    // Directed table: empty-table query, fill every slot, then the count extremes
    add_row(0, '0, MODE_QUERY, 0, 8'hFF, zero_p, 1, '{8'hFF, 4'd0, 1'b0, '0});
    for (int k = 0; k < DEPTH; k++) begin
      p.nx  = 16'(k * 4099);
      p.ny  = 16'(-k * 1237);
      p.nz  = 16'(k * 97 - 600);
      p.off = 16'(k * 1500 - 9000);
      if (k == 0) p = zero_p;
      else if (k == 1) p = max_p;
      else if (k == 2) p = min_p;
      else if (k == 3 || k == 9) p = mix_p;  // duplicate slots: lowest must win the tie
      add_row(0, '0, MODE_LOAD, k, k, p, 0, none);
    end
    add_row(1, 5'd1, MODE_QUERY, 0, 0, zero_p, 0, none);
    add_row(0, '0, MODE_QUERY, 0, 8'h01, zero_p, 1, '{8'h01, 4'd0, 1'b1, '0});
    add_row(1, 5'd16, MODE_QUERY, 0, 0, zero_p, 0, none);
    add_row(0, '0, MODE_QUERY, 0, 8'h02, mix_p, 0, none);
    add_row(0, '0, MODE_QUERY, 0, 8'h80, min_p, 0, none);
    add_row(0, '0, MODE_QUERY, 0, 8'h7F, max_p, 0, none);
    add_row(1, 5'd31, MODE_QUERY, 0, 0, zero_p, 0, none);
    add_row(0, '0, MODE_QUERY, 0, 8'h55, near_p, 0, none);
    add_row(1, 5'd0, MODE_QUERY, 0, 0, zero_p, 0, none);
    add_row(0, '0, MODE_QUERY, 0, 8'h00, max_p, 1, '{8'h00, 4'd0, 1'b0, '0});

    // Hold reset at the start, then release it
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) set_table_count(stim_rows[i].cfg_val);
      else begin
        send_item(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].exp);
        hold_off($urandom_range(0, 2));
      end
    end

    // Random phases, each under its own table_count
    sent = 0;
    burst_left = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: cnt = 5'd0;
        1: cnt = 5'd16;
        2: cnt = 5'd31;
        3: cnt = CNT_W'($urandom_range(17, 31));
        default: cnt = CNT_W'($urandom_range(1, 16));
      endcase
      set_table_count(cnt);
      phase_len = $urandom_range(30, 80);
      if (phase_len > RANDOM_ITEMS - sent) phase_len = RANDOM_ITEMS - sent;
      repeat (phase_len) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 12));
        end
        it.mode = ($urandom_range(0, 9) < 6) ? MODE_QUERY : MODE_LOAD;
        it.slot = SLOT_W'($urandom_range(0, DEPTH - 1));
        it.tag = TAG_W'($urandom);
        // Copies of stored planes give exact hits and ties
        if ($urandom_range(0, 9) < 4) begin
          it.p = shadow_planes[$urandom_range(0, DEPTH - 1)];
          if ($urandom_range(0, 1) == 1) it.p.off = it.p.off + 16'sd1;
        end else begin
          it.p.nx = pick_field();
          it.p.ny = pick_field();
          it.p.nz = pick_field();
          it.p.off = pick_field();
        end
        send_item(it, 0, none);
        burst_left--;
        sent++;
      end
    end

    hold_off(1);
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
